// ----- sv/ioq_pkg.sv -----
// Shared types, codes and helpers for the interval overlap query block.
// Used by ioq_ctrl, ioq_datapath and interval_overlap_query.
`timescale 1ns / 1ps

package ioq_pkg;

  localparam int TIME_W    = 32;
  localparam int IDX_W     = 10;
  localparam int SEG_CNT_W = 11;
  localparam int HITS_W    = 11;

  // Operation codes carried by the op field of an input beat.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Register index decoded from the configuration address.
  localparam logic [0:0] REG_SEGMENT_COUNT = 1'b0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic write;     // store the accepted entry
    logic start;     // latch the query range and clear the accumulators
    logic scan;      // step through the active table entries
    logic nbr_rd;    // read the entries next to the first and last hit
    logic load_out;  // move the finished result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_idle; // all entries read and every pipeline stage drained
  } status_t;

  // Positive difference, zero when the later time is not after the earlier.
  function automatic logic [TIME_W-1:0] pos_diff(input logic [TIME_W-1:0] later,
                                                 input logic [TIME_W-1:0] earlier);
    logic [TIME_W-1:0] d;
    d = (later > earlier) ? (later - earlier) : '0;
    return d;
  endfunction

endpackage

// ----- sv/ioq_ctrl.sv -----
// Controller state machine for the interval overlap query block.
// Depends on ioq_pkg for the command and status types and the op codes.
`timescale 1ns / 1ps

module ioq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              op,
  input  logic              out_stall,
  input  ioq_pkg::status_t  status,
  output logic              in_stall,
  output logic              out_valid,
  output ioq_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_NBR  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        cmd.write = accept && (op == ioq_pkg::OP_WRITE);
        cmd.start = accept && (op == ioq_pkg::OP_QUERY);
        if (cmd.start) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_idle) begin
          state_next = S_NBR;
        end
      end
      S_NBR: begin
        cmd.nbr_rd = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // The result waits here until the output register is free.
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/ioq_datapath.sv -----
// Datapath of the interval overlap query block: segment memories, scan
// pipeline, hit accumulators and the result register. Depends on ioq_pkg.
`timescale 1ns / 1ps

module ioq_datapath #(
  parameter int MAX_SEGMENTS = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  ioq_pkg::cmd_t                    cmd,
  output ioq_pkg::status_t                 status,
  input  logic [ioq_pkg::SEG_CNT_W-1:0]    segment_count,
  input  logic [ioq_pkg::IDX_W-1:0]        entry_index,
  input  logic [ioq_pkg::TIME_W-1:0]       entry_start_ms,
  input  logic [ioq_pkg::TIME_W-1:0]       entry_end_ms,
  input  logic                             entry_has_text,
  input  logic [ioq_pkg::TIME_W-1:0]       query_start_ms,
  input  logic [ioq_pkg::TIME_W-1:0]       query_end_ms,
  output logic                             found,
  output logic [ioq_pkg::IDX_W-1:0]        first_hit,
  output logic [ioq_pkg::IDX_W-1:0]        last_hit,
  output logic [ioq_pkg::HITS_W-1:0]       hit_count,
  output logic [ioq_pkg::TIME_W-1:0]       gap_before_ms,
  output logic [ioq_pkg::TIME_W-1:0]       gap_after_ms,
  output logic [ioq_pkg::TIME_W-1:0]       widest_gap_ms
);

  localparam int AW = $clog2(MAX_SEGMENTS);
  localparam int CW = (AW + 1 > ioq_pkg::SEG_CNT_W) ? AW + 1 : ioq_pkg::SEG_CNT_W;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_SEGMENTS);

  localparam int TW = ioq_pkg::TIME_W;
  localparam int NW = ioq_pkg::SEG_CNT_W;

  // Segment memories, one write port and one registered read port each.
  logic [TW-1:0] start_mem [MAX_SEGMENTS];
  logic [TW-1:0] end_mem   [MAX_SEGMENTS];
  logic          text_mem  [MAX_SEGMENTS];

  logic [TW-1:0] qs;
  logic [TW-1:0] qe;
  logic [NW-1:0] limit;
  logic [NW-1:0] idx;
  logic [AW-1:0] rd_idx;
  logic          rd_v;
  logic [TW-1:0] s_rd;
  logic [TW-1:0] e_rd;
  logic          t_rd;

  logic [NW-1:0] hits;
  logic [AW-1:0] first;
  logic [AW-1:0] last;
  logic [TW-1:0] first_start;
  logic [TW-1:0] last_end;
  logic [TW-1:0] gap;
  logic          gap_v;
  logic [TW-1:0] widest;

  logic [CW-1:0] seg_ext;
  logic [CW-1:0] active;
  logic [NW-1:0] limit_next;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          issue;
  logic          rd_en;
  logic [AW-1:0] rd_start_addr;
  logic [AW-1:0] rd_end_addr;
  logic          hit;
  logic          res_found;
  logic          has_after;
  logic [TW-1:0] res_before;
  logic [TW-1:0] res_after;

  // Counts above the table depth act as the full table; an empty or
  // inverted range scans nothing.
  assign seg_ext    = CW'(segment_count);
  assign active     = (seg_ext > MAX_C) ? MAX_C : seg_ext;
  assign limit_next = (query_end_ms > query_start_ms) ? NW'(active) : '0;

  assign wr_en   = cmd.write && (CW'(entry_index) < MAX_C);
  assign wr_addr = AW'(entry_index);

  assign issue         = cmd.scan && (idx < limit);
  assign rd_en         = issue || cmd.nbr_rd;
  assign rd_start_addr = cmd.nbr_rd ? AW'(last + 1'b1) : AW'(idx);
  assign rd_end_addr   = cmd.nbr_rd ? AW'(first - 1'b1) : AW'(idx);

  assign status.scan_idle = (idx >= limit) && !rd_v && !gap_v;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      start_mem[wr_addr] <= entry_start_ms;
      end_mem[wr_addr]   <= entry_end_ms;
      text_mem[wr_addr]  <= entry_has_text;
    end
    if (rd_en) begin
      s_rd <= start_mem[rd_start_addr];
      e_rd <= end_mem[rd_end_addr];
      t_rd <= text_mem[rd_start_addr];
    end
  end

  // Overlap min(end, qe) > max(start, qs) split into four parallel compares.
  assign hit = rd_v && t_rd && (e_rd > s_rd) && (e_rd > qs) && (qe > s_rd) && (qe > qs);

  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= '0;
      limit  <= '0;
      rd_v   <= 1'b0;
      gap_v  <= 1'b0;
      hits   <= '0;
      first  <= '0;
      last   <= '0;
      widest <= '0;
    end else if (cmd.start) begin
      qs     <= query_start_ms;
      qe     <= query_end_ms;
      limit  <= limit_next;
      idx    <= '0;
      rd_v   <= 1'b0;
      gap_v  <= 1'b0;
      hits   <= '0;
      first  <= '0;
      last   <= '0;
      widest <= '0;
    end else begin
      rd_v   <= issue;
      rd_idx <= AW'(idx);
      if (issue) begin
        idx <= idx + 1'b1;
      end
      gap_v <= hit && (hits != '0);
      if (hit) begin
        if (hits == '0) begin
          first       <= rd_idx;
          first_start <= s_rd;
        end else begin
          gap <= ioq_pkg::pos_diff(s_rd, last_end);
        end
        last     <= rd_idx;
        last_end <= e_rd;
        hits     <= hits + 1'b1;
      end
      // Second stage: fold the registered gap into the running maximum.
      if (gap_v && (gap > widest)) begin
        widest <= gap;
      end
    end
  end

  // Neighbor reads land in s_rd (entry after the last hit) and e_rd (entry
  // before the first hit) while the controller waits in its final state.
  assign res_found  = (hits != '0);
  assign has_after  = (CW'(last) + 1'b1) < CW'(limit);
  assign res_before = (res_found && (first != '0)) ?
                      ioq_pkg::pos_diff(first_start, e_rd) : '0;
  assign res_after  = (res_found && has_after) ? ioq_pkg::pos_diff(s_rd, last_end) : '0;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      found         <= res_found;
      first_hit     <= ioq_pkg::IDX_W'(first);
      last_hit      <= ioq_pkg::IDX_W'(last);
      hit_count     <= ioq_pkg::HITS_W'(hits);
      gap_before_ms <= res_before;
      gap_after_ms  <= res_after;
      widest_gap_ms <= widest;
    end
  end

endmodule

// ----- sv/interval_overlap_query.sv -----
// Interval overlap query: a table of time segments searched for a range.
// A write beat is stored when it is accepted. A query reads one entry per cycle over the active entries, where
// active is segment_count capped at the table depth, or 0 for an empty or inverted range.
// After the scan and the neighbor read, the result waits until the output register is free, and the
// next beat is taken once it is loaded, so later still while an earlier result is held.
// Reset clears control and count.
`timescale 1ns / 1ps

module interval_overlap_query #(
  parameter int MAX_SEGMENTS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  // Item input channel.
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          op,
  input  logic [ioq_pkg::IDX_W-1:0]     entry_index,
  input  logic [ioq_pkg::TIME_W-1:0]    entry_start_ms,
  input  logic [ioq_pkg::TIME_W-1:0]    entry_end_ms,
  input  logic                          entry_has_text,
  input  logic [ioq_pkg::TIME_W-1:0]    query_start_ms,
  input  logic [ioq_pkg::TIME_W-1:0]    query_end_ms,
  // Result output channel.
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          found,
  output logic [ioq_pkg::IDX_W-1:0]     first_hit,
  output logic [ioq_pkg::IDX_W-1:0]     last_hit,
  output logic [ioq_pkg::HITS_W-1:0]    hit_count,
  output logic [ioq_pkg::TIME_W-1:0]    gap_before_ms,
  output logic [ioq_pkg::TIME_W-1:0]    gap_after_ms,
  output logic [ioq_pkg::TIME_W-1:0]    widest_gap_ms,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [ioq_pkg::SEG_CNT_W-1:0] segment_count;
  logic                          cfg_write;
  ioq_pkg::cmd_t                 cmd;
  ioq_pkg::status_t              status;

  // The port never inserts wait states, so every access completes in its
  // access cycle. The register is decoded on the word address bit only.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count <= '0;
    end else if (cfg_write && (paddr[2] == ioq_pkg::REG_SEGMENT_COUNT)) begin
      segment_count <= pwdata[ioq_pkg::SEG_CNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == ioq_pkg::REG_SEGMENT_COUNT) ? 32'(segment_count) : '0;

  // The controller sequences a query through its scan, neighbor read and
  // result load; a write beat is stored in the same cycle it is accepted.
  // While a result waits in the output register, further beats are still
  // taken, and a new query holds in its last step until the register frees.
  ioq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .op        (op),
    .out_stall (out_stall),
    .status    (status),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // The datapath holds the segment memories and steps through the active
  // entries, one read per cycle, tracking first, last, count and gaps.
  ioq_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .segment_count  (segment_count),
    .entry_index    (entry_index),
    .entry_start_ms (entry_start_ms),
    .entry_end_ms   (entry_end_ms),
    .entry_has_text (entry_has_text),
    .query_start_ms (query_start_ms),
    .query_end_ms   (query_end_ms),
    .found          (found),
    .first_hit      (first_hit),
    .last_hit       (last_hit),
    .hit_count      (hit_count),
    .gap_before_ms  (gap_before_ms),
    .gap_after_ms   (gap_after_ms),
    .widest_gap_ms  (widest_gap_ms)
  );

endmodule
